// File: design/stereo_dual_tap_echo_macros.svh
// -----------------------------------------------------------------------------
// Assertion macros for the stereo dual-tap echo
// Concurrent checks sampled on the rising clock, muted while reset is low.
// -----------------------------------------------------------------------------
`ifndef STEREO_DUAL_TAP_ECHO_MACROS_SVH
`define STEREO_DUAL_TAP_ECHO_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SDTE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SDTE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/sdte_pkg.sv
// -----------------------------------------------------------------------------
// sdte_pkg
// Shared types and constants of the stereo dual-tap echo.
// -----------------------------------------------------------------------------
package sdte_pkg;

  localparam int MAX_LEN_DEF     = 131072;
  localparam int SAMPLE_BITS_DEF = 24;

  localparam int COEF_W  = 17;             // unsigned Q1.16
  localparam int LEN_W   = 17;
  localparam int CFG_W   = 34;
  localparam int CFG_IDX_W = 3;

  localparam logic [COEF_W-1:0] ONE_Q16 = 17'h10000;

  localparam logic [LEN_W-1:0]  LEN_RST  = 17'h1FFFF;
  localparam logic [COEF_W-1:0] DAMP_RST = 17'h10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TAP1_LEN   = 3'd0,
    REG_TAP2_LEN   = 3'd1,
    REG_TAP1_GAINS = 3'd2,
    REG_TAP2_GAINS = 3'd3,
    REG_FB_GAINS   = 3'd4,
    REG_CROSS_MIX  = 3'd5,
    REG_DAMPING    = 3'd6
  } sdte_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMUL,
    ST_CSUM,
    ST_TMUL,
    ST_TSUM,
    ST_DMUL,
    ST_DSUM,
    ST_WB
  } sdte_state_e;

  // Phase strobes from the sequencer to every lane
  typedef struct packed {
    logic cmul;
    logic csum;
    logic tmul;
    logic tsum;
    logic dmul;
    logic dsum;
    logic clr;
  } sdte_ctrl_t;

endpackage

// File: design/sdte_if.sv
// -----------------------------------------------------------------------------
// sdte_in_if / sdte_out_if
// Valid/ready stereo sample channels of the echo.
// -----------------------------------------------------------------------------
interface sdte_in_if import sdte_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;

  modport source (output valid, output left_in, output right_in, input ready);
  modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface sdte_out_if import sdte_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

// File: design/sdte_line.sv
// -----------------------------------------------------------------------------
// sdte_line
// One circular stereo delay line: memory, tap index and wrap tracking.
// -----------------------------------------------------------------------------
module sdte_line import sdte_pkg::*; #(
  parameter int MAX_LEN     = MAX_LEN_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            clr_i,
  input  logic                            rd_en_i,
  input  logic                            wr_en_i,
  input  logic [LEN_W-1:0]                len_i,
  input  logic [2*SAMPLE_BITS-1:0]        wr_data_i,
  output logic [2*SAMPLE_BITS-1:0]        rd_data_o
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LW = (AW + 1 > LEN_W) ? AW + 1 : LEN_W;
  localparam logic [LW-1:0] LIM_MAX = LW'(MAX_LEN - 1);

  logic [2*SAMPLE_BITS-1:0] mem [MAX_LEN];
  logic [2*SAMPLE_BITS-1:0] rd_q;
  logic [AW-1:0]            idx_q, idx_d;
  logic                     wrapped_q, wrapped_d;
  logic                     rd_ok_q;
  logic [LW-1:0]            len_w, lim, idx_inc;

  // Effective length is the register limited to 1 .. MAX_LEN-1
  always_comb begin
    len_w = LW'(len_i);
    if (len_w > LIM_MAX) begin
      lim = LIM_MAX;
    end else if (len_w == '0) begin
      lim = LW'(1);
    end else begin
      lim = len_w;
    end
    idx_inc   = LW'(idx_q) + LW'(1);
    idx_d     = idx_q;
    wrapped_d = wrapped_q;
    if (clr_i) begin
      idx_d     = '0;
      wrapped_d = 1'b0;
    end else if (wr_en_i) begin
      if (idx_inc >= lim) begin
        idx_d     = '0;
        wrapped_d = 1'b1;
      end else begin
        idx_d = idx_inc[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      wrapped_q <= 1'b0;
      rd_ok_q   <= 1'b0;
    end else begin
      idx_q     <= idx_d;
      wrapped_q <= wrapped_d;
      if (rd_en_i) begin
        rd_ok_q <= wrapped_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem[idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[idx_q] <= wr_data_i;
    end
  end

  // Entries not yet written since the last clear read as silence
  assign rd_data_o = rd_ok_q ? rd_q : '0;

endmodule

// File: design/sdte_lane.sv
// -----------------------------------------------------------------------------
// sdte_lane
// One channel of one tap: cross mix, feedback sum and damping lowpass.
// -----------------------------------------------------------------------------
module sdte_lane import sdte_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sdte_ctrl_t                    ctrl_i,
  input  logic signed [SAMPLE_BITS-1:0] d_self_i,
  input  logic signed [SAMPLE_BITS-1:0] d_other_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic [COEF_W-1:0]             gain_i,
  input  logic [COEF_W-1:0]             fb_i,
  input  logic [COEF_W-1:0]             cross_i,
  input  logic [COEF_W-1:0]             damp_i,
  output logic signed [SAMPLE_BITS-1:0] tap_o,
  output logic signed [SAMPLE_BITS-1:0] damped_o
);

  localparam int SB = SAMPLE_BITS;
  localparam int XW = SB + 3;          // crossed sample, kept unsaturated
  localparam int KW = COEF_W + 1;      // signed coefficient
  localparam int QW = XW + KW;         // product
  localparam logic signed [QW:0] HALF = (QW+1)'(32768);
  localparam logic signed [QW:0] SMAX = {{(QW+2-SB){1'b0}}, {(SB-1){1'b1}}};
  localparam logic signed [QW:0] SMIN = ~SMAX;

  logic signed [KW-1:0] cs, ccs, hs, hcs, gs, fbs;
  logic signed [XW-1:0] op_a1, op_b1;
  logic signed [KW-1:0] op_a2, op_b2;
  logic signed [QW-1:0] mul_a, mul_b;
  logic signed [QW-1:0] pa_q, pb_q;
  logic signed [QW:0]   sum_w, rnd_w;
  logic signed [SB-1:0] sat_w;
  logic signed [XW-1:0] x_q;
  logic signed [SB-1:0] t_q, old_q;

  assign cs  = signed'({1'b0, cross_i});
  assign ccs = signed'({1'b0, ONE_Q16}) - cs;
  assign hs  = signed'({1'b0, damp_i});
  assign hcs = signed'({1'b0, ONE_Q16}) - hs;
  assign gs  = signed'({1'b0, gain_i});
  assign fbs = signed'({1'b0, fb_i});

  // Two shared multipliers, operands picked by phase
  always_comb begin
    op_a1 = XW'(t_q);
    op_a2 = hs;
    op_b1 = XW'(old_q);
    op_b2 = hcs;
    if (ctrl_i.cmul) begin
      op_a1 = XW'(d_self_i);
      op_a2 = ccs;
      op_b1 = XW'(d_other_i);
      op_b2 = cs;
    end else if (ctrl_i.tmul) begin
      op_a1 = XW'(sample_i);
      op_a2 = gs;
      op_b1 = x_q;
      op_b2 = fbs;
    end
  end

  assign mul_a = op_a1 * op_a2;
  assign mul_b = op_b1 * op_b2;

  always_comb begin
    if (ctrl_i.tsum) begin
      sum_w = (QW+1)'(pa_q) - (QW+1)'(pb_q);
    end else begin
      sum_w = (QW+1)'(pa_q) + (QW+1)'(pb_q);
    end
    rnd_w = (sum_w + HALF) >>> 16;
    if (rnd_w > SMAX) begin
      sat_w = SMAX[SB-1:0];
    end else if (rnd_w < SMIN) begin
      sat_w = SMIN[SB-1:0];
    end else begin
      sat_w = rnd_w[SB-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cmul || ctrl_i.tmul || ctrl_i.dmul) begin
      pa_q <= mul_a;
      pb_q <= mul_b;
    end
    if (ctrl_i.csum) begin
      x_q <= rnd_w[XW-1:0];
    end
    if (ctrl_i.tsum) begin
      t_q <= sat_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      old_q <= '0;
    end else if (ctrl_i.clr) begin
      old_q <= '0;
    end else if (ctrl_i.dsum) begin
      old_q <= sat_w;
    end
  end

  assign tap_o    = t_q;
  assign damped_o = old_q;

endmodule

// File: design/sdte_merge.sv
// -----------------------------------------------------------------------------
// sdte_merge
// Combines the four lane tap values into the saturated stereo output.
// -----------------------------------------------------------------------------
module sdte_merge import sdte_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic signed [SAMPLE_BITS-1:0] l1_i,
  input  logic signed [SAMPLE_BITS-1:0] r1_i,
  input  logic signed [SAMPLE_BITS-1:0] l2_i,
  input  logic signed [SAMPLE_BITS-1:0] r2_i,
  output logic signed [SAMPLE_BITS-1:0] left_o,
  output logic signed [SAMPLE_BITS-1:0] right_o
);

  localparam int SB = SAMPLE_BITS;
  localparam logic signed [SB+1:0] SMAX = {3'b000, {(SB-1){1'b1}}};
  localparam logic signed [SB+1:0] SMIN = ~SMAX;

  logic signed [SB+1:0] sum_l, sum_r;

  assign sum_l = ((SB+2)'(l1_i) + (SB+2)'(l2_i)) <<< 1;
  assign sum_r = ((SB+2)'(r1_i) + (SB+2)'(r2_i)) <<< 1;

  always_comb begin
    if (sum_l > SMAX) begin
      left_o = SMAX[SB-1:0];
    end else if (sum_l < SMIN) begin
      left_o = SMIN[SB-1:0];
    end else begin
      left_o = sum_l[SB-1:0];
    end
    if (sum_r > SMAX) begin
      right_o = SMAX[SB-1:0];
    end else if (sum_r < SMIN) begin
      right_o = SMIN[SB-1:0];
    end else begin
      right_o = sum_r[SB-1:0];
    end
  end

endmodule

// File: design/stereo_dual_tap_echo.sv
// -----------------------------------------------------------------------------
// stereo_dual_tap_echo
// Two-tap stereo feedback echo with cross mixing and damping, four lanes.
//
//   port      dir  beat contents
//   in_if     in   left_in, right_in (signed Q1.23)
//   out_if    out  left_out, right_out (signed Q1.23, saturated)
//   cfg_*     in   cfg_idx_i selects register, cfg_data_i value, cfg_we_i
//
// For each item the accept cycle issues the line reads, then each lane runs
// cross, tap and damp phases of multiply then sum on its two multipliers,
// and the last state writes the damped pair back.
// After reset or a length write no clearing pass runs: each line reads as
// zero until its index first wraps. A held output beat stalls the sequencer
// in the damp multiply phase; input beats are taken only in the idle state.
// -----------------------------------------------------------------------------
`include "stereo_dual_tap_echo_macros.svh"

module stereo_dual_tap_echo import sdte_pkg::*; #(
  parameter int MAX_LEN     = MAX_LEN_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  sdte_in_if.sink              in_if,
  sdte_out_if.source           out_if,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int SB = SAMPLE_BITS;

  sdte_state_e state_q, state_d;
  sdte_ctrl_t  ctrl;
  logic        rd_en, wr_en, out_load, clr;

  logic [LEN_W-1:0]  len1_q, len2_q;
  logic [CFG_W-1:0]  gains1_q, gains2_q, fb_q;
  logic [COEF_W-1:0] cross_q, damp_q;

  logic signed [SB-1:0] in_l_q, in_r_q;
  logic [2*SB-1:0]      rd1, rd2;
  logic signed [SB-1:0] t_l1, t_r1, t_l2, t_r2;
  logic signed [SB-1:0] y_l1, y_r1, y_l2, y_r2;
  logic signed [SB-1:0] mix_l, mix_r;
  logic                 out_valid_q;
  logic signed [SB-1:0] out_l_q, out_r_q;

  // Configuration registers
  assign clr = cfg_we_i && (cfg_idx_i == REG_TAP1_LEN || cfg_idx_i == REG_TAP2_LEN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len1_q   <= LEN_RST;
      len2_q   <= LEN_RST;
      gains1_q <= '0;
      gains2_q <= '0;
      fb_q     <= '0;
      cross_q  <= '0;
      damp_q   <= DAMP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TAP1_LEN:   len1_q   <= cfg_data_i[LEN_W-1:0];
        REG_TAP2_LEN:   len2_q   <= cfg_data_i[LEN_W-1:0];
        REG_TAP1_GAINS: gains1_q <= cfg_data_i;
        REG_TAP2_GAINS: gains2_q <= cfg_data_i;
        REG_FB_GAINS:   fb_q     <= cfg_data_i;
        REG_CROSS_MIX:  cross_q  <= cfg_data_i[COEF_W-1:0];
        REG_DAMPING:    damp_q   <= cfg_data_i[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_if.valid) state_d = ST_CMUL;
      ST_CMUL: state_d = ST_CSUM;
      ST_CSUM: state_d = ST_TMUL;
      ST_TMUL: state_d = ST_TSUM;
      ST_TSUM: state_d = ST_DMUL;
      ST_DMUL: if (!out_valid_q || out_if.ready) state_d = ST_DSUM;
      ST_DSUM: state_d = ST_WB;
      ST_WB:   state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    ctrl        = '0;
    ctrl.clr    = clr;
    in_if.ready = 1'b0;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    out_load    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_if.ready = 1'b1;
        rd_en       = in_if.valid;
      end
      ST_CMUL: ctrl.cmul = 1'b1;
      ST_CSUM: ctrl.csum = 1'b1;
      ST_TMUL: ctrl.tmul = 1'b1;
      ST_TSUM: ctrl.tsum = 1'b1;
      ST_DMUL: begin
        ctrl.dmul = 1'b1;
        out_load  = !out_valid_q || out_if.ready;
      end
      ST_DSUM: ctrl.dsum = 1'b1;
      ST_WB:   wr_en     = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      in_l_q <= in_if.left_in;
      in_r_q <= in_if.right_in;
    end
  end

  sdte_line #(.MAX_LEN(MAX_LEN), .SAMPLE_BITS(SB)) u_line1 (
    .clk_i, .rst_ni, .clr_i(clr), .rd_en_i(rd_en), .wr_en_i(wr_en),
    .len_i(len1_q), .wr_data_i({y_l1, y_r1}), .rd_data_o(rd1)
  );

  sdte_line #(.MAX_LEN(MAX_LEN), .SAMPLE_BITS(SB)) u_line2 (
    .clk_i, .rst_ni, .clr_i(clr), .rd_en_i(rd_en), .wr_en_i(wr_en),
    .len_i(len2_q), .wr_data_i({y_l2, y_r2}), .rd_data_o(rd2)
  );

  sdte_lane #(.SAMPLE_BITS(SB)) u_lane_l1 (
    .clk_i, .rst_ni, .ctrl_i(ctrl),
    .d_self_i(rd1[2*SB-1:SB]), .d_other_i(rd1[SB-1:0]), .sample_i(in_l_q),
    .gain_i(gains1_q[2*COEF_W-1:COEF_W]), .fb_i(fb_q[2*COEF_W-1:COEF_W]),
    .cross_i(cross_q), .damp_i(damp_q), .tap_o(t_l1), .damped_o(y_l1)
  );

  sdte_lane #(.SAMPLE_BITS(SB)) u_lane_r1 (
    .clk_i, .rst_ni, .ctrl_i(ctrl),
    .d_self_i(rd1[SB-1:0]), .d_other_i(rd1[2*SB-1:SB]), .sample_i(in_r_q),
    .gain_i(gains1_q[COEF_W-1:0]), .fb_i(fb_q[2*COEF_W-1:COEF_W]),
    .cross_i(cross_q), .damp_i(damp_q), .tap_o(t_r1), .damped_o(y_r1)
  );

  sdte_lane #(.SAMPLE_BITS(SB)) u_lane_l2 (
    .clk_i, .rst_ni, .ctrl_i(ctrl),
    .d_self_i(rd2[2*SB-1:SB]), .d_other_i(rd2[SB-1:0]), .sample_i(in_l_q),
    .gain_i(gains2_q[2*COEF_W-1:COEF_W]), .fb_i(fb_q[COEF_W-1:0]),
    .cross_i(cross_q), .damp_i(damp_q), .tap_o(t_l2), .damped_o(y_l2)
  );

  sdte_lane #(.SAMPLE_BITS(SB)) u_lane_r2 (
    .clk_i, .rst_ni, .ctrl_i(ctrl),
    .d_self_i(rd2[SB-1:0]), .d_other_i(rd2[2*SB-1:SB]), .sample_i(in_r_q),
    .gain_i(gains2_q[COEF_W-1:0]), .fb_i(fb_q[COEF_W-1:0]),
    .cross_i(cross_q), .damp_i(damp_q), .tap_o(t_r2), .damped_o(y_r2)
  );

  sdte_merge #(.SAMPLE_BITS(SB)) u_merge (
    .l1_i(t_l1), .r1_i(t_r1), .l2_i(t_l2), .r2_i(t_r2),
    .left_o(mix_l), .right_o(mix_r)
  );

  // Output register holds the beat until the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_l_q <= mix_l;
      out_r_q <= mix_r;
    end
  end

  assign out_if.valid     = out_valid_q;
  assign out_if.left_out  = out_l_q;
  assign out_if.right_out = out_r_q;

  `SDTE_ASSERT_NOW(a_no_overwrite, clk_i, rst_ni, out_load,
    !out_valid_q || out_if.ready, "output beat overwritten")
  `SDTE_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni,
    state_q == ST_DMUL && !out_load, state_q == ST_DMUL, "damp phase left while stalled")
  `SDTE_ASSERT_NEXT(a_load_valid, clk_i, rst_ni, out_load,
    out_valid_q && state_q == ST_DSUM, "loaded beat not presented")

endmodule
